/* sv/spyp_pkg.sv */
// ----------------------------------------------------------------------------
// spyp_pkg
// Widths, formats and register indexes for the yaw/pitch point transform.
// ----------------------------------------------------------------------------
package spyp_pkg;

    // coordinates are signed, 1/1024 m per lsb
    localparam int COORD_WIDTH = 20;
    // coefficients are signed with two integer bits
    localparam int COEF_WIDTH  = 16;
    localparam int COEF_FRAC   = COEF_WIDTH - 2;

    // yaw stage: coord x coef products, their sum, and the rounded result
    localparam int PROD1_W = COORD_WIDTH + COEF_WIDTH;
    localparam int SUM1_W  = PROD1_W + 1;
    localparam int ROT1_W  = SUM1_W - COEF_FRAC;

    // pitch stage: rotated x times coef, sum and rounded result
    localparam int PROD2_W = ROT1_W + COEF_WIDTH;
    localparam int SUM2_W  = PROD2_W + 1;
    localparam int ROT2_W  = SUM2_W - COEF_FRAC;

    // after the offset is added, before saturation
    localparam int OSUM_W  = ROT2_W + 1;

    localparam int CFG_DATA_W = (COORD_WIDTH > COEF_WIDTH) ? COORD_WIDTH : COEF_WIDTH;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [OSUM_W-1:0]      osum_t;

    localparam coef_t COEF_ONE = coef_t'(1) <<< COEF_FRAC;

    localparam logic signed [SUM1_W-1:0] RND1 = SUM1_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [SUM2_W-1:0] RND2 = SUM2_W'(1) <<< (COEF_FRAC - 1);

    localparam osum_t COORD_HI = osum_t'((OSUM_W'(1) <<< (COORD_WIDTH - 1)) - OSUM_W'(1));
    localparam osum_t COORD_LO = -COORD_HI - osum_t'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_YAW    = 3'd0,
        REG_SIN_YAW    = 3'd1,
        REG_COS_PITCH  = 3'd2,
        REG_SIN_PITCH  = 3'd3,
        REG_OFFSET_X   = 3'd4,
        REG_OFFSET_Y   = 3'd5,
        REG_OFFSET_Z   = 3'd6,
        REG_RIGHT_SIDE = 3'd7
    } cfg_index_t;

    typedef struct packed {
        coord_t value;
        logic   clipped;
    } sat_t;

    function automatic sat_t sat_coord(input osum_t v);
        sat_t r;
        if (v > COORD_HI) begin
            r.value   = COORD_HI[COORD_WIDTH-1:0];
            r.clipped = 1'b1;
        end else if (v < COORD_LO) begin
            r.value   = COORD_LO[COORD_WIDTH-1:0];
            r.clipped = 1'b1;
        end else begin
            r.value   = v[COORD_WIDTH-1:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

endpackage

/* sv/sensor_point_yaw_pitch_transform.sv */
// ----------------------------------------------------------------------------
// sensor_point_yaw_pitch_transform
// Rotates a sensor point by yaw then pitch, adds the mount offset, saturates.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle unless the output stalls; set by the five-stage multiply/add pipeline
// the whole pipeline holds while a result waits at the output
// reset clears all valid bits and loads identity rotation, zero offsets, left side
module sensor_point_yaw_pitch_transform
    import spyp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  coord_t                s_in_x,
    input  coord_t                s_in_y,
    input  coord_t                s_in_z,
    input  logic                  s_in_last,

    output logic                  m_valid,
    input  logic                  m_ready,
    output coord_t                m_out_x,
    output coord_t                m_out_y,
    output coord_t                m_out_z,
    output logic                  m_out_last,
    output logic                  m_saturated
);

    // configuration registers
    coef_t  cos_yaw_reg, sin_yaw_reg, cos_pitch_reg, sin_pitch_reg;
    coord_t offset_x_reg, offset_y_reg, offset_z_reg;
    logic   right_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_yaw_reg    <= COEF_ONE;
            sin_yaw_reg    <= '0;
            cos_pitch_reg  <= COEF_ONE;
            sin_pitch_reg  <= '0;
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            offset_z_reg   <= '0;
            right_side_reg <= 1'b0;
        end else if (cfg_wen) begin
            case (cfg_index_t'(cfg_index))
                REG_COS_YAW:    cos_yaw_reg    <= cfg_wdata[COEF_WIDTH-1:0];
                REG_SIN_YAW:    sin_yaw_reg    <= cfg_wdata[COEF_WIDTH-1:0];
                REG_COS_PITCH:  cos_pitch_reg  <= cfg_wdata[COEF_WIDTH-1:0];
                REG_SIN_PITCH:  sin_pitch_reg  <= cfg_wdata[COEF_WIDTH-1:0];
                REG_OFFSET_X:   offset_x_reg   <= cfg_wdata[COORD_WIDTH-1:0];
                REG_OFFSET_Y:   offset_y_reg   <= cfg_wdata[COORD_WIDTH-1:0];
                REG_OFFSET_Z:   offset_z_reg   <= cfg_wdata[COORD_WIDTH-1:0];
                REG_RIGHT_SIDE: right_side_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output register is free or being drained
    logic advance;
    logic m_valid_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // ---------------- stage 1: yaw products ----------------
    logic                        v1_reg, last1_reg;
    logic signed [PROD1_W-1:0]   xc1_reg, ys1_reg, xs1_reg, yc1_reg;
    coord_t                      z1_reg;

    // ---------------- stage 2: yaw sums, rounded ----------------
    logic                        v2_reg, last2_reg;
    logic signed [SUM1_W-1:0]    xr_sum, yr_sum;
    logic signed [ROT1_W-1:0]    xr2_reg, yr2_reg;
    coord_t                      z2_reg;

    assign xr_sum = SUM1_W'(xc1_reg) - SUM1_W'(ys1_reg) + RND1;
    assign yr_sum = SUM1_W'(xs1_reg) + SUM1_W'(yc1_reg) + RND1;

    // ---------------- stage 3: pitch products ----------------
    logic                        v3_reg, last3_reg;
    logic signed [PROD2_W-1:0]   xc3_reg, zs3_reg, zc3_reg, xs3_reg;
    logic signed [ROT1_W-1:0]    yr3_reg;

    // ---------------- stage 4: pitch sums, offsets ----------------
    logic                        v4_reg, last4_reg;
    logic signed [SUM2_W-1:0]    px_sum, pz_sum;
    logic signed [ROT2_W-1:0]    px_rot, pz_rot;
    osum_t                       px4_next, py4_next, pz4_next;
    osum_t                       px4_reg, py4_reg, pz4_reg;

    assign px_sum = SUM2_W'(xc3_reg) + SUM2_W'(zs3_reg) + RND2;
    assign pz_sum = SUM2_W'(zc3_reg) - SUM2_W'(xs3_reg) + RND2;
    // dropping the fraction bits after adding one half is round to nearest
    assign px_rot = px_sum[SUM2_W-1:COEF_FRAC];
    assign pz_rot = pz_sum[SUM2_W-1:COEF_FRAC];

    always_comb begin
        px4_next = OSUM_W'(px_rot) + OSUM_W'(offset_x_reg);
        pz4_next = OSUM_W'(pz_rot) + OSUM_W'(offset_z_reg);
        if (right_side_reg) begin
            py4_next = OSUM_W'(yr3_reg) - OSUM_W'(offset_y_reg);
        end else begin
            py4_next = OSUM_W'(yr3_reg) + OSUM_W'(offset_y_reg);
        end
    end

    // ---------------- stage 5: saturate into output register ----------------
    sat_t   sat_x, sat_y, sat_z;
    coord_t m_out_x_reg, m_out_y_reg, m_out_z_reg;
    logic   m_out_last_reg, m_saturated_reg;

    assign sat_x = sat_coord(px4_reg);
    assign sat_y = sat_coord(py4_reg);
    assign sat_z = sat_coord(pz4_reg);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            m_valid_reg <= v4_reg;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (advance) begin
            xc1_reg   <= s_in_x * cos_yaw_reg;
            ys1_reg   <= s_in_y * sin_yaw_reg;
            xs1_reg   <= s_in_x * sin_yaw_reg;
            yc1_reg   <= s_in_y * cos_yaw_reg;
            z1_reg    <= s_in_z;
            last1_reg <= s_in_last;

            xr2_reg   <= xr_sum[SUM1_W-1:COEF_FRAC];
            yr2_reg   <= yr_sum[SUM1_W-1:COEF_FRAC];
            z2_reg    <= z1_reg;
            last2_reg <= last1_reg;

            xc3_reg   <= xr2_reg * cos_pitch_reg;
            zs3_reg   <= z2_reg * sin_pitch_reg;
            zc3_reg   <= z2_reg * cos_pitch_reg;
            xs3_reg   <= xr2_reg * sin_pitch_reg;
            yr3_reg   <= yr2_reg;
            last3_reg <= last2_reg;

            px4_reg   <= px4_next;
            py4_reg   <= py4_next;
            pz4_reg   <= pz4_next;
            last4_reg <= last3_reg;

            m_out_x_reg     <= sat_x.value;
            m_out_y_reg     <= sat_y.value;
            m_out_z_reg     <= sat_z.value;
            m_out_last_reg  <= last4_reg;
            m_saturated_reg <= sat_x.clipped | sat_y.clipped | sat_z.clipped;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_x     = m_out_x_reg;
    assign m_out_y     = m_out_y_reg;
    assign m_out_z     = m_out_z_reg;
    assign m_out_last  = m_out_last_reg;
    assign m_saturated = m_saturated_reg;

    // ---------------- assertions ----------------
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while the result beat is stalled");

    a_accept_enters_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted beat did not reach stage 1");

    a_flag_means_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_out_x == COORD_HI[COORD_WIDTH-1:0] || m_out_x == COORD_LO[COORD_WIDTH-1:0] ||
             m_out_y == COORD_HI[COORD_WIDTH-1:0] || m_out_y == COORD_LO[COORD_WIDTH-1:0] ||
             m_out_z == COORD_HI[COORD_WIDTH-1:0] || m_out_z == COORD_LO[COORD_WIDTH-1:0]))
        else $error("saturated flag set with no coordinate at a range limit");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

endmodule
